// ===== rtl/graph_dfs_path_engine_assert.svh =====
// Assertion macros for the graph search engine.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef GRAPH_DFS_PATH_ENGINE_ASSERT_SVH
`define GRAPH_DFS_PATH_ENGINE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define GDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);
// Plain invariant checked at every clock edge outside reset.
`define GDP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`endif

// ===== rtl/gdp_pkg.sv =====
// Shared constants and types for the graph search engine.
// No dependencies.
`default_nettype none
package gdp_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_DEGREE   = 16;
    localparam int VALUE_BITS   = 16;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int DW           = $clog2(MAX_DEGREE);
    localparam int CW           = $clog2(MAX_DEGREE + 1);
    localparam int NW           = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        ACT_NEW   = 3'd0,
        ACT_ADD   = 3'd1,
        ACT_EDGE  = 3'd2,
        ACT_CHECK = 3'd3,
        ACT_FIND  = 3'd4,
        ACT_PATH  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_NOVERTEX = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNREACH  = 3'd4
    } t_status;

    typedef struct packed {
        logic [VW-1:0] vtx;
        logic [CW-1:0] nxt;
    } t_frame;
endpackage
`default_nettype wire

// ===== rtl/graph_dfs_path_engine.sv =====
// Graph store with depth-first path search. One beat in, one or more beats out;
// the input is not ready while a beat is in work. Adds and finds scan the value
// memory one stored vertex at a time; edge commands scan neighbour lists entry by
// entry; a path query examines neighbour entries and pops the stack in the search,
// then emits one beat per path vertex when the receiver is ready, all paced by the
// single read port of each memory.
// Uses gdp_pkg and gdp_ram.
`default_nettype none
module graph_dfs_path_engine
    import gdp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // vertex_value, first_vertex, second_vertex
    input  wire logic [2:0]  i_s_axis_tuser,  // action
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,  // edge_present, vertex_number, result_value
    output logic [2:0]       o_m_axis_tuser,  // status
    output logic             o_m_axis_tlast   // last_result
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_VS_RD, S_VS_CK, S_CA_RD, S_CB_RD, S_CB_CAP, S_LS_RD, S_LS_CK,
        S_ADD_B, S_D_TOP, S_D_FRM, S_D_CNT, S_D_NB, S_D_END, S_P_RD, S_P_EMIT, S_OUT
    } t_state;

    t_state                r_state;
    t_action               r_act;
    logic [VALUE_BITS-1:0] r_val;
    logic [VW-1:0]         r_a, r_b, r_u, r_w, r_fv, r_cur, r_k;
    logic [NW-1:0]         r_cnt, r_i, r_sp;
    logic [CW-1:0]         r_ca, r_cb, r_fn;
    logic                  r_l1, r_pass, r_more;
    logic [MAX_VERTICES-1:0] r_vld, r_vis;
    t_status               r_st;
    logic                  r_edge, r_last, r_ov;
    logic [VW-1:0]         r_num;
    logic [15:0]           r_rval;

    logic val_we, cnt_we, nbr_we, par_we, stk_we;
    logic [VW-1:0] val_wa, val_ra, cnt_wa, cnt_ra, par_ra;
    logic [VW+DW-1:0] nbr_wa, nbr_ra;
    logic [VW-1:0] stk_wa, stk_ra, nbr_wd;
    logic [CW-1:0] cnt_wd, cnt_rd, cnt_eff, lim;
    logic [VALUE_BITS-1:0] val_rd;
    logic [VW-1:0] nbr_rd, par_rd;
    t_frame stk_wd, stk_rd;
    logic ls_done, ls_hit, add_ok, add_full, vs_miss;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {1'b0, r_rval, r_num, r_edge};
    assign o_m_axis_tuser  = r_st;
    assign o_m_axis_tlast  = r_last;

    always_comb begin
        lim      = r_pass ? r_cb : r_ca;
        ls_done  = ((r_state == S_LS_RD) && ({1'b0, r_i[CW-1:0]} >= {1'b0, lim}))
                || ((r_state == S_LS_CK) && (nbr_rd == r_w));
        ls_hit   = (r_state == S_LS_CK);
        add_full = (r_ca == CW'(MAX_DEGREE)) || ((r_a != r_b) && (r_cb == CW'(MAX_DEGREE)));
        add_ok   = ls_done && !ls_hit && (r_act == ACT_EDGE) && !add_full;
        vs_miss  = (r_state == S_VS_RD) && (r_i >= r_cnt);
        cnt_eff  = '0;
        unique case (r_state)
            S_CB_RD:  cnt_eff = r_vld[r_a] ? cnt_rd : '0;
            S_CB_CAP: cnt_eff = r_vld[r_b] ? cnt_rd : '0;
            S_D_CNT:  cnt_eff = r_vld[r_fv] ? cnt_rd : '0;
            default:  cnt_eff = '0;
        endcase
        val_we = ((r_state == S_DISP) && (r_act == ACT_NEW))
              || (vs_miss && (r_act == ACT_ADD) && (r_cnt < NW'(MAX_VERTICES)));
        val_wa = (r_state == S_DISP) ? '0 : r_cnt[VW-1:0];
        val_ra = (r_state == S_P_RD) ? r_cur : r_i[VW-1:0];
        cnt_we = add_ok || (r_state == S_ADD_B);
        cnt_wa = (r_state == S_ADD_B) ? r_b : r_a;
        cnt_wd = (r_state == S_ADD_B) ? r_cb + 1'b1 : r_ca + 1'b1;
        unique case (r_state)
            S_CA_RD: cnt_ra = r_a;
            S_CB_RD: cnt_ra = r_b;
            default: cnt_ra = stk_rd.vtx;
        endcase
        nbr_we = cnt_we;
        nbr_wa = (r_state == S_ADD_B) ? {r_b, r_cb[DW-1:0]} : {r_a, r_ca[DW-1:0]};
        nbr_wd = (r_state == S_ADD_B) ? r_a : r_b;
        nbr_ra = (r_state == S_D_CNT) ? {r_fv, r_fn[DW-1:0]} : {r_u, r_i[DW-1:0]};
        par_we = (r_state == S_D_NB) && !r_vis[nbr_rd] && (r_sp < NW'(MAX_VERTICES));
        par_ra = r_cur;
        stk_we = ((r_state == S_DISP) && (r_act == ACT_PATH)) || par_we
              || ((r_state == S_D_CNT) && (r_fn < cnt_eff));
        stk_wa = '0;
        stk_wd = '{vtx: r_a, nxt: '0};
        if (r_state == S_D_CNT) begin
            stk_wa = VW'(r_sp - 1'b1);
            stk_wd = '{vtx: r_fv, nxt: r_fn + 1'b1};
        end else if (r_state == S_D_NB) begin
            stk_wa = r_sp[VW-1:0];
            stk_wd = '{vtx: nbr_rd, nxt: '0};
        end
        stk_ra = VW'(r_sp - 1'b1);
    end

    gdp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VALUE_BITS)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_wa), .i_wdata(r_val),
        .i_raddr(val_ra), .o_rdata(val_rd));
    gdp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(CW)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd));
    gdp_ram #(.DEPTH(MAX_VERTICES * MAX_DEGREE), .WIDTH(VW)) u_nbr (
        .i_clk(i_clk), .i_we(nbr_we), .i_waddr(nbr_wa), .i_wdata(nbr_wd),
        .i_raddr(nbr_ra), .o_rdata(nbr_rd));
    gdp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(nbr_rd), .i_wdata(r_fv),
        .i_raddr(par_ra), .o_rdata(par_rd));
    gdp_ram #(.DEPTH(MAX_VERTICES), .WIDTH($bits(t_frame))) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_vld   <= '0;
            r_vis   <= '0;
            r_sp    <= '0;
        end else begin
            if (r_state == S_IDLE) begin
                r_edge <= 1'b0;
                r_num  <= '0;
                r_rval <= '0;
                r_last <= 1'b1;
                r_more <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_act   <= t_action'(i_s_axis_tuser);
                        r_val   <= i_s_axis_tdata[15:0];
                        r_a     <= i_s_axis_tdata[21:16];
                        r_b     <= i_s_axis_tdata[27:22];
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_i    <= '0;
                    r_pass <= 1'b0;
                    r_u    <= r_a;
                    r_w    <= r_b;
                    r_state <= S_OUT;
                    r_ov    <= 1'b1;
                    r_st    <= ST_NOVERTEX;
                    priority if (r_act == ACT_NEW) begin
                        r_vld  <= '0;
                        r_cnt  <= NW'(1);
                        r_st   <= ST_OK;
                        r_rval <= r_val;
                    end else if (r_act == ACT_ADD || r_act == ACT_FIND) begin
                        r_ov    <= 1'b0;
                        r_state <= S_VS_RD;
                    end else if ((r_act == ACT_EDGE || r_act == ACT_CHECK || r_act == ACT_PATH)
                                 && ({1'b0, r_a} < r_cnt) && ({1'b0, r_b} < r_cnt)) begin
                        r_ov <= 1'b0;
                        if (r_act == ACT_PATH) begin
                            r_vis        <= '0;
                            r_vis[r_a]   <= 1'b1;
                            r_sp         <= NW'(1);
                            r_state      <= S_D_TOP;
                        end else begin
                            r_state <= S_CA_RD;
                        end
                    end else begin
                        r_st <= ST_NOVERTEX;
                    end
                end
                S_VS_RD: begin
                    if (vs_miss) begin
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                        if (r_act == ACT_FIND) begin
                            r_st <= ST_NOVERTEX;
                        end else if (r_cnt >= NW'(MAX_VERTICES)) begin
                            r_st <= ST_FULL;
                        end else begin
                            r_st   <= ST_OK;
                            r_num  <= r_cnt[VW-1:0];
                            r_rval <= r_val;
                            r_vld[r_cnt[VW-1:0]] <= 1'b0;
                            r_cnt  <= r_cnt + 1'b1;
                        end
                    end else begin
                        r_state <= S_VS_CK;
                    end
                end
                S_VS_CK: begin
                    if (val_rd == r_val) begin
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                        r_st    <= (r_act == ACT_ADD) ? ST_EXISTS : ST_OK;
                        r_num   <= r_i[VW-1:0];
                        r_rval  <= r_val;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_VS_RD;
                    end
                end
                S_CA_RD:  r_state <= S_CB_RD;
                S_CB_RD: begin
                    r_ca    <= cnt_eff;
                    r_state <= S_CB_CAP;
                end
                S_CB_CAP: begin
                    r_cb    <= cnt_eff;
                    r_state <= S_LS_RD;
                end
                S_LS_RD, S_LS_CK: begin
                    if (ls_done) begin
                        r_state <= S_OUT;
                        r_ov    <= 1'b1;
                        r_st    <= ST_OK;
                        if (r_act == ACT_CHECK) begin
                            if (!r_pass) begin
                                r_l1    <= ls_hit;
                                r_pass  <= 1'b1;
                                r_u     <= r_b;
                                r_w     <= r_a;
                                r_i     <= '0;
                                r_ov    <= 1'b0;
                                r_state <= S_LS_RD;
                            end else begin
                                r_edge <= r_l1 & ls_hit;
                            end
                        end else if (ls_hit) begin
                            r_st <= ST_EXISTS;
                        end else if (add_full) begin
                            r_st <= ST_FULL;
                        end else begin
                            r_vld[r_a] <= 1'b1;
                            if (r_a != r_b) begin
                                r_ov    <= 1'b0;
                                r_state <= S_ADD_B;
                            end
                        end
                    end else if (r_state == S_LS_RD) begin
                        r_state <= S_LS_CK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_LS_RD;
                    end
                end
                S_ADD_B: begin
                    r_vld[r_b] <= 1'b1;
                    r_st       <= ST_OK;
                    r_ov       <= 1'b1;
                    r_state    <= S_OUT;
                end
                S_D_TOP: r_state <= S_D_FRM;
                S_D_FRM: begin
                    r_fv    <= stk_rd.vtx;
                    r_fn    <= stk_rd.nxt;
                    r_state <= S_D_CNT;
                end
                S_D_CNT: begin
                    if (r_fn < cnt_eff) begin
                        r_state <= S_D_NB;
                    end else begin
                        r_sp    <= r_sp - 1'b1;
                        r_state <= (r_sp == NW'(1)) ? S_D_END : S_D_TOP;
                    end
                end
                S_D_NB: begin
                    if (par_we) begin
                        r_vis[nbr_rd] <= 1'b1;
                        r_sp          <= r_sp + 1'b1;
                    end
                    r_state <= S_D_TOP;
                end
                S_D_END: begin
                    r_cur <= r_b;
                    r_k   <= '0;
                    if (r_vis[r_b]) begin
                        r_state <= S_P_RD;
                    end else begin
                        r_st    <= ST_UNREACH;
                        r_ov    <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_P_RD: r_state <= S_P_EMIT;
                S_P_EMIT: begin
                    r_st    <= ST_OK;
                    r_num   <= r_cur;
                    r_rval  <= val_rd;
                    r_last  <= (r_cur == r_a) || (r_k == VW'(MAX_VERTICES - 1));
                    r_more  <= !((r_cur == r_a) || (r_k == VW'(MAX_VERTICES - 1)));
                    r_cur   <= par_rd;
                    r_k     <= r_k + 1'b1;
                    r_ov    <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_more <= r_more;
                    r_last <= r_last;
                    r_edge <= r_edge;
                    r_num  <= r_num;
                    r_rval <= r_rval;
                    if (i_m_axis_tready) begin
                        r_ov    <= 1'b0;
                        r_state <= r_more ? S_P_RD : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "graph_dfs_path_engine_assert.svh"
    `GDP_ASSERT_ALWAYS(a_no_overlap, !(o_s_axis_tready && o_m_axis_tvalid), "ready while output pending")
    `GDP_ASSERT_ALWAYS(a_cnt_range, r_cnt <= NW'(MAX_VERTICES), "vertex count overflow")
    `GDP_ASSERT_ALWAYS(a_sp_range, r_sp <= NW'(MAX_VERTICES), "search stack overflow")
    `GDP_ASSERT_IMP(a_last_idle, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, ##1 o_s_axis_tready, "no return to idle after last beat")
endmodule
`default_nettype wire

// ===== rtl/gdp_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module gdp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== verif/graph_dfs_path_engine_tb.sv =====
// Self-checking testbench for graph_dfs_path_engine: directed table then random graphs.
// Results are checked against an in-bench predictor of the graph store and search.
// Depends on gdp_pkg and the graph_dfs_path_engine RTL.
`timescale 1ns / 100ps
module graph_dfs_path_engine_tb;
    import gdp_pkg::*;

    localparam logic [2:0] ACT_BAD_LO = 3'd6;
    localparam logic [2:0] ACT_BAD_HI = 3'd7;
    localparam int         PATH_CAP   = 64;
    localparam int         CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [2:0]  st;
        logic        edge_hit;
        logic [5:0]  num;
        logic [15:0] val;
        logic        last;
    } t_beat;

    typedef struct {
        logic [2:0]  act;
        logic [15:0] v;
        logic [5:0]  a;
        logic [5:0]  b;
        bit          typed;
        t_beat       exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic [2:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    graph_dfs_path_engine uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // Predicted graph state.
    int unsigned g_count;
    logic [15:0] g_val [MAX_VERTICES];
    logic [5:0]  g_nbr [MAX_VERTICES][MAX_DEGREE];
    int unsigned g_deg [MAX_VERTICES];
    bit          g_seen [MAX_VERTICES];
    logic [5:0]  g_par [MAX_VERTICES];
    int unsigned stk_v [MAX_VERTICES];
    int unsigned stk_n [MAX_VERTICES];

    t_beat step_beats[$];
    t_beat pending_beats[$];
    t_row  rows[$];
    int    errors = 0;
    int    cycles = 0;
    bit    hold_go;
    bit    send_quiet;
    bit    recv_quiet;

    function automatic void emit(logic [2:0] st, logic e, logic [5:0] n, logic [15:0] v,
                                 logic l);
        t_beat bt;
        bt.st = st; bt.edge_hit = e; bt.num = n; bt.val = v; bt.last = l;
        step_beats.push_back(bt);
    endfunction

    function automatic bit has_neighbour(int unsigned v, int unsigned w);
        for (int i = 0; i < g_deg[v]; i++)
            if (g_nbr[v][i] == w) return 1;
        return 0;
    endfunction

    function automatic int value_slot(logic [15:0] v);
        for (int i = 0; i < g_count; i++)
            if (g_val[i] == v) return i;
        return -1;
    endfunction

    function automatic void search_from(int unsigned start);
        int unsigned sp;
        int unsigned v;
        int unsigned w;
        for (int i = 0; i < MAX_VERTICES; i++) g_seen[i] = 0;
        g_seen[start] = 1;
        stk_v[0] = start;
        stk_n[0] = 0;
        sp = 1;
        while (sp > 0) begin
            v = stk_v[sp-1];
            if (stk_n[sp-1] < g_deg[v]) begin
                w = g_nbr[v][stk_n[sp-1]];
                stk_n[sp-1]++;
                if (!g_seen[w] && sp < MAX_VERTICES) begin
                    g_seen[w] = 1;
                    g_par[w] = v[5:0];
                    stk_v[sp] = w;
                    stk_n[sp] = 0;
                    sp++;
                end
            end else begin
                sp--;
            end
        end
    endfunction

    function automatic void graph_step(logic [2:0] act, logic [15:0] v, logic [5:0] a,
                                       logic [5:0] b);
        bit in_rng;
        int d;
        int k;
        bit done;
        logic [5:0] cur;
        step_beats.delete();
        in_rng = (a < g_count) && (b < g_count);
        case (act)
            ACT_NEW: begin
                for (int i = 0; i < MAX_VERTICES; i++) g_deg[i] = 0;
                g_val[0] = v;
                g_count = 1;
                emit(ST_OK, 0, 0, v, 1);
            end
            ACT_ADD: begin
                d = value_slot(v);
                if (d >= 0) begin
                    emit(ST_EXISTS, 0, d[5:0], v, 1);
                end else if (g_count >= MAX_VERTICES) begin
                    emit(ST_FULL, 0, 0, 0, 1);
                end else begin
                    g_val[g_count] = v;
                    g_deg[g_count] = 0;
                    emit(ST_OK, 0, g_count[5:0], v, 1);
                    g_count++;
                end
            end
            ACT_EDGE: begin
                if (!in_rng) begin
                    emit(ST_NOVERTEX, 0, 0, 0, 1);
                end else if (has_neighbour(a, b)) begin
                    emit(ST_EXISTS, 0, 0, 0, 1);
                end else if (g_deg[a] >= MAX_DEGREE || (a != b && g_deg[b] >= MAX_DEGREE)) begin
                    emit(ST_FULL, 0, 0, 0, 1);
                end else begin
                    g_nbr[a][g_deg[a]] = b;
                    g_deg[a]++;
                    if (a != b) begin
                        g_nbr[b][g_deg[b]] = a;
                        g_deg[b]++;
                    end
                    emit(ST_OK, 0, 0, 0, 1);
                end
            end
            ACT_CHECK: begin
                if (!in_rng)
                    emit(ST_NOVERTEX, 0, 0, 0, 1);
                else
                    emit(ST_OK, has_neighbour(a, b) && has_neighbour(b, a), 0, 0, 1);
            end
            ACT_FIND: begin
                d = value_slot(v);
                if (d >= 0)
                    emit(ST_OK, 0, d[5:0], g_val[d], 1);
                else
                    emit(ST_NOVERTEX, 0, 0, 0, 1);
            end
            ACT_PATH: begin
                if (!in_rng) begin
                    emit(ST_NOVERTEX, 0, 0, 0, 1);
                end else begin
                    search_from(a);
                    if (!g_seen[b]) begin
                        emit(ST_UNREACH, 0, 0, 0, 1);
                    end else begin
                        cur = b;
                        k = 0;
                        forever begin
                            done = (cur == a) || (k + 1 >= PATH_CAP);
                            emit(ST_OK, 0, cur, g_val[cur], done);
                            k++;
                            if (done) break;
                            cur = g_par[cur];
                        end
                    end
                end
            end
            default: emit(ST_NOVERTEX, 0, 0, 0, 1);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        if (send_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_row(t_row r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= r.act;
        s_data  <= {4'b0, r.b, r.a, r.v};
        do @(posedge i_clk); while (!s_ready);
        graph_step(r.act, r.v, r.a, r.b);
        if (r.typed)
            pending_beats.push_back(r.exp);
        else
            foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    endtask

    task automatic send_op(logic [2:0] act, logic [15:0] v, logic [5:0] a, logic [5:0] b);
        t_row r;
        r.act = act; r.v = v; r.a = a; r.b = b; r.typed = 0;
        send_row(r);
    endtask

    function automatic void add_row(logic [2:0] act, logic [15:0] v, logic [5:0] a,
                                    logic [5:0] b, bit typed, logic [2:0] st, logic e,
                                    logic [5:0] n, logic [15:0] rv);
        t_row r;
        r.act = act; r.v = v; r.a = a; r.b = b; r.typed = typed;
        r.exp.st = st; r.exp.edge_hit = e; r.exp.num = n; r.exp.val = rv; r.exp.last = 1;
        rows.push_back(r);
    endfunction

    task automatic send_mixed(int unsigned span);
        int r;
        logic [5:0] a;
        logic [5:0] b;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        a = 6'($urandom_range(0, span));
        b = 6'($urandom_range(0, span));
        if (g_count > 0 && $urandom_range(0, 1))
            v = g_val[$urandom_range(0, g_count - 1)];
        else
            v = 16'($urandom_range(0, 65535));
        if (r < 28)      send_op(ACT_EDGE, v, a, b);
        else if (r < 48) send_op(ACT_PATH, v, a, b);
        else if (r < 63) send_op(ACT_CHECK, v, a, b);
        else if (r < 78) send_op(ACT_FIND, v, a, b);
        else if (r < 94) send_op(ACT_ADD, v, a, b);
        else             send_op(r[0] ? ACT_BAD_HI : ACT_BAD_LO, v, a, b);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("graph_dfs_path_engine test failed");
            $finish;
        end
    end

    initial begin : receiver
        int stall;
        int hold;
        t_beat want;
        stall = 0;
        hold = 0;
        recv_quiet = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) begin
                if (pending_beats.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: status %0d num %0d val %h last %0b",
                                 m_user, m_data[6:1], m_data[22:7], m_last);
                end else begin
                    want = pending_beats.pop_front();
                    if (m_user !== want.st || m_data[0] !== want.edge_hit ||
                        m_data[6:1] !== want.num || m_data[22:7] !== want.val ||
                        m_data[23] !== 1'b0 || m_last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp st %0d e %0b n %0d v %h l %0b, got st %0d e %0b n %0d v %h l %0b",
                                     want.st, want.edge_hit, want.num, want.val, want.last,
                                     m_user, m_data[0], m_data[6:1], m_data[22:7], m_last);
                    end
                end
            end
            if (hold_go) begin
                hold_go = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 199) == 0) recv_quiet = !recv_quiet;
                if (!recv_quiet && $urandom_range(0, 99) < 30)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
                m_ready <= (stall == 0);
            end
        end
    end

    initial begin
        hold_go = 0;
        send_quiet = 0;
        g_count = 0;
        for (int i = 0; i < MAX_VERTICES; i++) g_deg[i] = 0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = ACT_NEW;

        add_row(ACT_PATH,   16'h0000, 0,  0,  1, ST_NOVERTEX, 0, 0, 16'h0000);
        add_row(ACT_FIND,   16'h1234, 0,  0,  1, ST_NOVERTEX, 0, 0, 16'h0000);
        add_row(ACT_BAD_LO, 16'hFFFF, 63, 63, 1, ST_NOVERTEX, 0, 0, 16'h0000);
        add_row(ACT_BAD_HI, 16'h0000, 0,  0,  1, ST_NOVERTEX, 0, 0, 16'h0000);
        add_row(ACT_ADD,    16'hFFFF, 0,  0,  1, ST_OK,       0, 0, 16'hFFFF);
        add_row(ACT_ADD,    16'hFFFF, 0,  0,  1, ST_EXISTS,   0, 0, 16'hFFFF);
        add_row(ACT_NEW,    16'h0000, 0,  0,  1, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_ADD,    16'hFFFF, 0,  0,  1, ST_OK,       0, 1, 16'hFFFF);
        add_row(ACT_ADD,    16'h8001, 0,  0,  1, ST_OK,       0, 2, 16'h8001);
        add_row(ACT_EDGE,   16'h0000, 0,  1,  1, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_EDGE,   16'h0000, 1,  0,  1, ST_EXISTS,   0, 0, 16'h0000);
        add_row(ACT_EDGE,   16'h0000, 2,  2,  1, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_EDGE,   16'h0000, 0,  63, 1, ST_NOVERTEX, 0, 0, 16'h0000);
        add_row(ACT_CHECK,  16'h0000, 1,  0,  1, ST_OK,       1, 0, 16'h0000);
        add_row(ACT_CHECK,  16'h0000, 0,  2,  1, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_CHECK,  16'h0000, 63, 0,  1, ST_NOVERTEX, 0, 0, 16'h0000);
        add_row(ACT_PATH,   16'h0000, 0,  1,  0, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_PATH,   16'h0000, 1,  1,  0, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_PATH,   16'h0000, 0,  2,  1, ST_UNREACH,  0, 0, 16'h0000);
        add_row(ACT_FIND,   16'h8001, 0,  0,  0, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_EDGE,   16'h0000, 1,  2,  0, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_PATH,   16'h0000, 0,  2,  0, ST_OK,       0, 0, 16'h0000);
        add_row(ACT_PATH,   16'h0000, 2,  63, 1, ST_NOVERTEX, 0, 0, 16'h0000);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_row(rows[i]);

        // Fill the store, with a few repeated values and overflow adds.
        send_op(ACT_NEW, 16'($urandom_range(0, 65535)), 0, 0);
        for (int i = 1; i < 67; i++) begin
            if (i % 30 == 0)
                send_op(ACT_ADD, g_val[$urandom_range(0, g_count - 1)], 0, 0);
            else
                send_op(ACT_ADD, 16'($urandom_range(0, 65535)), 0, 0);
        end
        for (int i = 0; i < 31; i++) send_op(ACT_EDGE, 0, 6'(i), 6'(i + 1));
        hold_go = 1;
        send_op(ACT_PATH, 0, 0, 31);
        send_op(ACT_PATH, 0, 31, 0);
        for (int i = 0; i < 6; i++) send_op(ACT_EDGE, 0, 7, 6'($urandom_range(8, 63)));
        for (int i = 0; i < 20; i++) send_mixed(63);

        // Small sparse graph where unreachable targets are common.
        send_op(ACT_NEW, 16'($urandom_range(0, 65535)), 0, 0);
        for (int i = 0; i < 7; i++) send_op(ACT_ADD, 16'($urandom_range(0, 65535)), 0, 0);
        for (int i = 0; i < 12; i++) send_mixed(9);
        s_valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("graph_dfs_path_engine test passed");
        end else begin
            $display("graph_dfs_path_engine test failed");
        end
        $finish;
    end

endmodule
